// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

// next-cycle implication that also holds across reset
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== rtl/rcpd_pkg.sv =====
// types and constants of the rc pwm channel decoder
// no dependencies
package rcpd_pkg;

   localparam int CFG_BITS    = 12;
   localparam int CH_FIELD    = 3;
   localparam int TS_BITS     = 32;
   localparam int IDX_BITS    = 3;

   localparam logic [CFG_BITS-1:0] MIN_WIDTH_RST  = 12'd900;
   localparam logic [CFG_BITS-1:0] MAX_WIDTH_RST  = 12'd2100;
   localparam logic [CFG_BITS-1:0] ALT_THRESH_RST = 12'd1300;
   localparam logic [CFG_BITS-1:0] LOIT_THRESH_RST = 12'd1700;
   localparam logic [CFG_BITS-1:0] LAND_THRESH_RST = 12'd1500;
   localparam logic [CFG_BITS-1:0] LOCK_THRESH_RST = 12'd1500;

   typedef enum logic {
      OP_CAPTURE  = 1'b0,
      OP_OVERFLOW = 1'b1
   } op_type;

   typedef enum logic [IDX_BITS-1:0] {
      REG_MIN_WIDTH   = 3'd0,
      REG_MAX_WIDTH   = 3'd1,
      REG_ALT_THRESH  = 3'd2,
      REG_LOIT_THRESH = 3'd3,
      REG_LAND_THRESH = 3'd4,
      REG_LOCK_THRESH = 3'd5
   } reg_index_type;

   typedef enum logic [2:0] {
      MODE_STABILIZE = 3'd0,
      MODE_ALTITUDE  = 3'd1,
      MODE_LOITER    = 3'd2,
      MODE_LANDING   = 3'd3,
      MODE_LOCKED    = 3'd4
   } flight_mode_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] min_width;
      logic [CFG_BITS-1:0] max_width;
      logic [CFG_BITS-1:0] altitude_threshold;
      logic [CFG_BITS-1:0] loiter_threshold;
      logic [CFG_BITS-1:0] land_threshold;
      logic [CFG_BITS-1:0] lock_threshold;
   } cfg_type;

endpackage

// ===== rtl/rcpd_interfaces.sv =====
// valid/ready channel interfaces of the rc pwm channel decoder
// depends on rcpd_pkg
interface rcpd_req_if import rcpd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                operation;
   logic [CH_FIELD-1:0] channel;
   logic                timer_group;
   logic [TS_BITS-1:0]  timestamp;

   modport source (output valid, operation, channel, timer_group, timestamp, input ready);
   modport sink (input valid, operation, channel, timer_group, timestamp, output ready);
endinterface

interface rcpd_rsp_if import rcpd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CH_FIELD-1:0] out_channel;
   logic [CFG_BITS-1:0] width;
   logic                width_updated;
   logic [2:0]          flight_mode;

   modport source (output valid, out_channel, width, width_updated, flight_mode, input ready);
   modport sink (input valid, out_channel, width, width_updated, flight_mode, output ready);
endinterface

interface rcpd_csr_if import rcpd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [IDX_BITS-1:0] index;
   logic [CFG_BITS-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/rcpd_mode_decode.sv =====
// flight mode decode from the lock, land and mode channel widths
// depends on rcpd_pkg
module rcpd_mode_decode import rcpd_pkg::*; (
   input  cfg_type             cfg,
   input  logic [CFG_BITS-1:0] lock_width,
   input  logic [CFG_BITS-1:0] land_width,
   input  logic [CFG_BITS-1:0] mode_width,
   output flight_mode_type     flight_mode
);

   always_comb begin
      priority if (lock_width < cfg.lock_threshold) begin
         flight_mode = MODE_LOCKED;
      end else if (land_width > cfg.land_threshold) begin
         flight_mode = MODE_LANDING;
      end else if (mode_width < cfg.altitude_threshold) begin
         flight_mode = MODE_STABILIZE;
      end else if (mode_width < cfg.loiter_threshold) begin
         flight_mode = MODE_ALTITUDE;
      end else begin
         flight_mode = MODE_LOITER;
      end
   end

endmodule

// ===== rtl/rc_pwm_channel_decoder_unit.sv =====
// rc pwm channel decoder: per-channel pulse width capture and flight mode
// depends on rcpd_pkg, rcpd_interfaces, rcpd_mode_decode
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   operation, channel, timer_group, timestamp
//  rsp      out  valid/ready   out_channel, width, width_updated, flight_mode
//  csr      in   valid/ready   index, data (always ready)
//
// one request per cycle while the response is not stalled
// two stages: request register, then the channel read-modify-write into the response register
// flight_mode is decoded from the stored widths that the pending response left
// synchronous reset restores the register defaults and clears all channel state
// a stalled response holds the second stage; the request register still takes one more request
module rc_pwm_channel_decoder_unit import rcpd_pkg::*; #(
   parameter int CHANNELS          = 7,
   parameter int GROUP0_CHANNELS   = 4,
   parameter int GROUP0_TIMER_BITS = 16,
   parameter int GROUP1_TIMER_BITS = 32,
   parameter int OVERFLOW_BITS     = 4
) (
   input  logic       clock,
   input  logic       reset,
   rcpd_req_if.sink   req_chan,
   rcpd_rsp_if.source rsp_chan,
   rcpd_csr_if.sink   csr_chan
);

   localparam int CH_BITS = $clog2(CHANNELS);
   localparam logic [TS_BITS-1:0] G0_MASK = TS_BITS'((64'd1 << GROUP0_TIMER_BITS) - 64'd1);
   localparam logic [TS_BITS-1:0] G1_MASK = TS_BITS'((64'd1 << GROUP1_TIMER_BITS) - 64'd1);
   localparam logic [OVERFLOW_BITS-1:0] SAT = '1;

   cfg_type cfg_ff;

   logic                in_valid_ff, in_valid_in;
   logic                in_op_ff;
   logic [CH_FIELD-1:0] in_ch_ff;
   logic                in_grp_ff;
   logic [TS_BITS-1:0]  in_ts_ff;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CH_FIELD-1:0] rsp_ch_ff, rsp_ch_in;
   logic [CFG_BITS-1:0] rsp_width_ff, rsp_width_in;
   logic                rsp_upd_ff, rsp_upd_in;

   logic                     level_ff [CHANNELS];
   logic                     level_in [CHANNELS];
   logic [TS_BITS-1:0]       rise_ff  [CHANNELS];
   logic [TS_BITS-1:0]       rise_in  [CHANNELS];
   logic [OVERFLOW_BITS-1:0] cnt_ff   [CHANNELS];
   logic [OVERFLOW_BITS-1:0] cnt_in   [CHANNELS];
   logic [CFG_BITS-1:0]      acc_ff   [CHANNELS];
   logic [CFG_BITS-1:0]      acc_in   [CHANNELS];

   logic                accept, advance;
   logic                ch_ok, is_g0, is_capture, in_range, upd;
   logic [CH_BITS-1:0]  idx;
   logic [63:0]         cnt_wide;
   logic [TS_BITS-1:0]  t_masked, ovf_term, pulse;
   logic [CFG_BITS-1:0] lock_w, land_w, mode_w;
   flight_mode_type     mode;

   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign accept         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign in_valid_in  = accept || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         in_op_ff  <= req_chan.operation;
         in_ch_ff  <= req_chan.channel;
         in_grp_ff <= req_chan.timer_group;
         in_ts_ff  <= req_chan.timestamp;
      end
      if (advance) begin
         rsp_ch_ff    <= rsp_ch_in;
         rsp_width_ff <= rsp_width_in;
         rsp_upd_ff   <= rsp_upd_in;
      end
   end

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_width          <= MIN_WIDTH_RST;
         cfg_ff.max_width          <= MAX_WIDTH_RST;
         cfg_ff.altitude_threshold <= ALT_THRESH_RST;
         cfg_ff.loiter_threshold   <= LOIT_THRESH_RST;
         cfg_ff.land_threshold     <= LAND_THRESH_RST;
         cfg_ff.lock_threshold     <= LOCK_THRESH_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            REG_MIN_WIDTH:   cfg_ff.min_width          <= csr_chan.data;
            REG_MAX_WIDTH:   cfg_ff.max_width          <= csr_chan.data;
            REG_ALT_THRESH:  cfg_ff.altitude_threshold <= csr_chan.data;
            REG_LOIT_THRESH: cfg_ff.loiter_threshold   <= csr_chan.data;
            REG_LAND_THRESH: cfg_ff.land_threshold     <= csr_chan.data;
            REG_LOCK_THRESH: cfg_ff.lock_threshold     <= csr_chan.data;
            default: begin
            end
         endcase
      end
   end

   // channel read and pulse width
   assign is_capture = (in_op_ff == OP_CAPTURE);
   assign ch_ok      = 32'(in_ch_ff) < CHANNELS;
   assign is_g0      = 32'(in_ch_ff) < GROUP0_CHANNELS;
   assign idx        = CH_BITS'(in_ch_ff);
   assign cnt_wide   = 64'(cnt_ff[idx]);
   assign t_masked   = in_ts_ff & (is_g0 ? G0_MASK : G1_MASK);
   assign ovf_term   = is_g0 ? TS_BITS'(cnt_wide << GROUP0_TIMER_BITS)
                             : TS_BITS'(cnt_wide << GROUP1_TIMER_BITS);
   assign pulse      = t_masked + ovf_term - rise_ff[idx];
   assign in_range   = (pulse >= TS_BITS'(cfg_ff.min_width))
                    && (pulse <= TS_BITS'(cfg_ff.max_width));
   assign upd        = is_capture && ch_ok && level_ff[idx] && in_range;

   always_comb begin
      for (int i = 0; i < CHANNELS; i++) begin
         level_in[i] = level_ff[i];
         rise_in[i]  = rise_ff[i];
         cnt_in[i]   = cnt_ff[i];
         acc_in[i]   = acc_ff[i];
      end
      if (!is_capture) begin
         for (int i = 0; i < CHANNELS; i++) begin
            if (((in_grp_ff == 1'b0) == (i < GROUP0_CHANNELS)) && (cnt_ff[i] != SAT)) begin
               cnt_in[i] = cnt_ff[i] + 1'b1;
            end
         end
      end else if (ch_ok) begin
         level_in[idx] = !level_ff[idx];
         if (level_ff[idx]) begin
            if (in_range) begin
               acc_in[idx] = pulse[CFG_BITS-1:0];
            end
         end else begin
            rise_in[idx] = t_masked;
            cnt_in[idx]  = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            level_ff[i] <= 1'b0;
            rise_ff[i]  <= '0;
            cnt_ff[i]   <= '0;
            acc_ff[i]   <= '0;
         end
      end else if (advance) begin
         for (int i = 0; i < CHANNELS; i++) begin
            level_ff[i] <= level_in[i];
            rise_ff[i]  <= rise_in[i];
            cnt_ff[i]   <= cnt_in[i];
            acc_ff[i]   <= acc_in[i];
         end
      end
   end

   // response fields
   always_comb begin
      rsp_ch_in    = is_capture ? in_ch_ff : '0;
      rsp_upd_in   = upd;
      rsp_width_in = '0;
      if (is_capture && ch_ok) begin
         rsp_width_in = upd ? pulse[CFG_BITS-1:0] : acc_ff[idx];
      end
   end

   // lock, land and mode channels follow the first group
   if (GROUP0_CHANNELS < CHANNELS) begin : g_lock
      assign lock_w = acc_ff[GROUP0_CHANNELS];
   end else begin : g_no_lock
      assign lock_w = '0;
   end
   if (GROUP0_CHANNELS + 1 < CHANNELS) begin : g_land
      assign land_w = acc_ff[GROUP0_CHANNELS + 1];
   end else begin : g_no_land
      assign land_w = '0;
   end
   if (GROUP0_CHANNELS + 2 < CHANNELS) begin : g_mode
      assign mode_w = acc_ff[GROUP0_CHANNELS + 2];
   end else begin : g_no_mode
      assign mode_w = '0;
   end

   rcpd_mode_decode u_mode (
      .cfg         (cfg_ff),
      .lock_width  (lock_w),
      .land_width  (land_w),
      .mode_width  (mode_w),
      .flight_mode (mode)
   );

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_channel   = rsp_ch_ff;
   assign rsp_chan.width         = rsp_width_ff;
   assign rsp_chan.width_updated = rsp_upd_ff;
   assign rsp_chan.flight_mode   = mode;

endmodule

// ===== rtl/rcpd_checker.sv =====
// port-level checks of the rc pwm channel decoder, bound to the top level
// depends on assert_macros.svh and rc_pwm_channel_decoder_unit
`include "assert_macros.svh"

module rcpd_checker #(
   parameter int CHANNELS = 7
) (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [2:0]  rsp_out_channel,
   input logic [11:0] rsp_width,
   input logic        rsp_width_updated,
   input logic [2:0]  rsp_flight_mode
);

   logic rsp_stall;
   logic ch_bad;

   assign rsp_stall = rsp_valid && !rsp_ready;
   assign ch_bad    = 32'(rsp_out_channel) >= CHANNELS;

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall,
      rsp_valid && $stable(rsp_out_channel) && $stable(rsp_width)
      && $stable(rsp_width_updated) && $stable(rsp_flight_mode))

   `ASSERT_SAME(a_bad_channel, clock, reset, rsp_valid && ch_bad,
      rsp_width == 12'd0 && !rsp_width_updated)

   `ASSERT_SAME(a_req_blocks_only_on_full, clock, reset, !req_ready, rsp_valid)

   `ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && req_ready)

endmodule

bind rc_pwm_channel_decoder_unit rcpd_checker #(
   .CHANNELS (CHANNELS)
) u_rcpd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_out_channel   (rsp_chan.out_channel),
   .rsp_width         (rsp_chan.width),
   .rsp_width_updated (rsp_chan.width_updated),
   .rsp_flight_mode   (rsp_chan.flight_mode)
);

// ===== test/tb_top.sv =====
// self-checking testbench of rc_pwm_channel_decoder_unit: directed and random capture events
// and overflow ticks, checked against a pulse width scoreboard; depends on rcpd_pkg, rcpd_interfaces
`timescale 1ns / 100ps

module tb_top import rcpd_pkg::*; ();

   localparam int CHANNEL_COUNT = 7;
   localparam int GROUP0_COUNT  = 4;
   localparam int LOCK_CH       = GROUP0_COUNT;
   localparam int LAND_CH       = GROUP0_COUNT + 1;
   localparam int MODE_CH       = GROUP0_COUNT + 2;
   localparam logic [3:0] OVF_SAT = 4'hF;

   typedef struct {
      logic [2:0]      out_channel;
      logic [11:0]     width;
      logic            width_updated;
      flight_mode_type flight_mode;
   } pulse_report_type;

   class pulse_width_scoreboard;
      cfg_type          cfg;
      logic             level[CHANNEL_COUNT];
      logic [31:0]      rise_ts[CHANNEL_COUNT];
      logic [3:0]       ovf_count[CHANNEL_COUNT];
      logic [11:0]      stored_width[CHANNEL_COUNT];
      pulse_report_type pending[$];
      int               errors;
      int               checked;
      int               widths_stored;

      function new();
         cfg.min_width          = MIN_WIDTH_RST;
         cfg.max_width          = MAX_WIDTH_RST;
         cfg.altitude_threshold = ALT_THRESH_RST;
         cfg.loiter_threshold   = LOIT_THRESH_RST;
         cfg.land_threshold     = LAND_THRESH_RST;
         cfg.lock_threshold     = LOCK_THRESH_RST;
         for (int i = 0; i < CHANNEL_COUNT; i++) begin
            level[i]        = 1'b0;
            rise_ts[i]      = '0;
            ovf_count[i]    = '0;
            stored_width[i] = '0;
         end
         errors = 0;
         checked = 0;
         widths_stored = 0;
      endfunction

      function void set_reg(reg_index_type idx, logic [11:0] value);
         case (idx)
            REG_MIN_WIDTH:   cfg.min_width = value;
            REG_MAX_WIDTH:   cfg.max_width = value;
            REG_ALT_THRESH:  cfg.altitude_threshold = value;
            REG_LOIT_THRESH: cfg.loiter_threshold = value;
            REG_LAND_THRESH: cfg.land_threshold = value;
            REG_LOCK_THRESH: cfg.lock_threshold = value;
            default: ;
         endcase
      endfunction

      function flight_mode_type current_mode();
         flight_mode_type m;
         if (stored_width[MODE_CH] < cfg.altitude_threshold) m = MODE_STABILIZE;
         else if (stored_width[MODE_CH] < cfg.loiter_threshold) m = MODE_ALTITUDE;
         else m = MODE_LOITER;
         if (stored_width[LAND_CH] > cfg.land_threshold) m = MODE_LANDING;
         if (stored_width[LOCK_CH] < cfg.lock_threshold) m = MODE_LOCKED;
         return m;
      endfunction

      function void note_request(op_type op, logic [2:0] ch, logic grp, logic [31:0] ts);
         pulse_report_type r;
         logic [31:0]      t;
         logic [31:0]      w;
         r.out_channel = '0;
         r.width = '0;
         r.width_updated = 1'b0;
         if (op == OP_OVERFLOW) begin
            for (int i = 0; i < CHANNEL_COUNT; i++)
               if ((grp == 1'b0) == (i < GROUP0_COUNT) && ovf_count[i] != OVF_SAT)
                  ovf_count[i] = ovf_count[i] + 4'd1;
         end else begin
            r.out_channel = ch;
            if (ch < CHANNEL_COUNT) begin
               t = (ch < GROUP0_COUNT) ? {16'h0, ts[15:0]} : ts;
               if (level[ch]) begin
                  if (ch < GROUP0_COUNT)
                     w = t + ({28'h0, ovf_count[ch]} << 16) - rise_ts[ch];
                  else
                     w = t - rise_ts[ch];
                  if (w >= {20'h0, cfg.min_width} && w <= {20'h0, cfg.max_width}) begin
                     stored_width[ch] = w[11:0];
                     r.width_updated = 1'b1;
                     widths_stored++;
                  end
                  level[ch] = 1'b0;
               end else begin
                  rise_ts[ch]   = t;
                  ovf_count[ch] = '0;
                  level[ch]     = 1'b1;
               end
               r.width = stored_width[ch];
            end
         end
         r.flight_mode = current_mode();
         pending.push_back(r);
      endfunction

      function void check_response(logic [2:0] ch, logic [11:0] w, logic upd, logic [2:0] fm);
         pulse_report_type e;
         if (pending.size() == 0) begin
            $error("response with no request pending");
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (ch !== e.out_channel) begin
            $error("out_channel expected %0d got %0d", e.out_channel, ch);
            errors++;
         end
         if (w !== e.width) begin
            $error("width expected %0d got %0d", e.width, w);
            errors++;
         end
         if (upd !== e.width_updated) begin
            $error("width_updated expected %0d got %0d", e.width_updated, upd);
            errors++;
         end
         if (fm !== e.flight_mode) begin
            $error("flight_mode expected %0d got %0d", e.flight_mode, fm);
            errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   int   req_idle_pct;
   int   rsp_idle_pct;
   int   rsp_hold_cycles;
   int   sent;
   int   settings_used;

   rcpd_req_if req_if();
   rcpd_rsp_if rsp_if();
   rcpd_csr_if csr_if();

   pulse_width_scoreboard sb = new();

   rc_pwm_channel_decoder_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("FAIL");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            sb.check_response(rsp_if.out_channel, rsp_if.width, rsp_if.width_updated,
                              rsp_if.flight_mode);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles <= rsp_hold_cycles - 1;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
         end
      end
   end

   task automatic send_event(op_type op, logic [2:0] ch, logic grp, logic [31:0] ts);
      while ($urandom_range(99) < req_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.operation   <= op;
      req_if.channel     <= ch;
      req_if.timer_group <= grp;
      req_if.timestamp   <= ts;
      do @(posedge clock); while (!req_if.ready);
      sb.note_request(op, ch, grp, ts);
      if (!(op == OP_CAPTURE && ch >= CHANNEL_COUNT))
         sent++;
   endtask

   task automatic capture(logic [2:0] ch, logic [31:0] ts);
      send_event(OP_CAPTURE, ch, 1'($urandom_range(1)), ts);
   endtask

   task automatic tick(logic grp);
      send_event(OP_OVERFLOW, 3'($urandom_range(7)), grp, $urandom);
   endtask

   task automatic wait_drained();
      req_if.valid <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(reg_index_type idx, logic [11:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      sb.set_reg(idx, value);
   endtask

   task automatic load_settings(logic [11:0] min_w, logic [11:0] max_w, logic [11:0] alt,
                                logic [11:0] loit, logic [11:0] land, logic [11:0] lock);
      write_reg(REG_MIN_WIDTH, min_w);
      write_reg(REG_MAX_WIDTH, max_w);
      write_reg(REG_ALT_THRESH, alt);
      write_reg(REG_LOIT_THRESH, loit);
      write_reg(REG_LAND_THRESH, land);
      write_reg(REG_LOCK_THRESH, lock);
      csr_if.valid <= 1'b0;
      settings_used++;
   endtask

   task automatic load_random_settings();
      load_settings(12'($urandom_range(400, 1200)), 12'($urandom_range(1600, 2600)),
                    12'($urandom_range(800, 2200)), 12'($urandom_range(800, 2200)),
                    12'($urandom_range(800, 2200)), 12'($urandom_range(800, 2200)));
   endtask

   // rise, the timer wraps in between, fall; sometimes extra ticks break a first-group width
   task automatic pulse_sequence();
      logic [2:0]  ch;
      logic        grp;
      logic [31:0] rise, fall, w;
      logic [32:0] sum;
      int          lo, hi, pick, wraps, extra;
      ch  = 3'($urandom_range(CHANNEL_COUNT - 1));
      grp = (ch >= GROUP0_COUNT);
      if (sb.level[ch])
         capture(ch, $urandom);
      lo = (sb.cfg.min_width > 50) ? sb.cfg.min_width - 50 : 0;
      hi = (sb.cfg.max_width < 4045) ? sb.cfg.max_width + 50 : 4095;
      pick = $urandom_range(99);
      if (pick < 60) w = $urandom_range(lo, hi);
      else if (pick < 85) w = $urandom_range(4095);
      else w = $urandom;
      rise = $urandom;
      if (!grp) begin
         sum   = {17'h0, rise[15:0]} + {1'b0, w};
         wraps = int'(sum[32:16]);
         fall  = {16'($urandom_range(65535)), sum[15:0]};
      end else begin
         sum   = {1'b0, rise} + {1'b0, w};
         wraps = int'(sum[32]);
         fall  = sum[31:0];
      end
      if (wraps > 20) wraps = $urandom_range(20);
      extra = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : 0;
      capture(ch, rise);
      repeat (wraps + extra) begin
         if ($urandom_range(3) == 0) tick(~grp);
         tick(grp);
      end
      capture(ch, fall);
   endtask

   task automatic run_random(int n);
      int target, midpoint, pick;
      bit paused;
      target   = sent + n;
      midpoint = sent + n / 2;
      paused   = 1'b0;
      while (sent < target) begin
         if (!paused && sent >= midpoint) begin
            wait_drained();
            paused = 1'b1;
         end
         pick = $urandom_range(99);
         if (pick < 75) begin
            pulse_sequence();
         end else if (pick < 90) begin
            send_event(OP_CAPTURE, 3'($urandom_range(7)), 1'($urandom_range(1)), $urandom);
         end else begin
            repeat ($urandom_range(1, 20)) tick(1'($urandom_range(1)));
         end
      end
      wait_drained();
   endtask

   initial begin
      reset <= 1'b1;
      req_if.valid <= 1'b0;
      req_if.operation <= OP_CAPTURE;
      req_if.channel <= '0;
      req_if.timer_group <= 1'b0;
      req_if.timestamp <= '0;
      csr_if.valid <= 1'b0;
      csr_if.index <= REG_MIN_WIDTH;
      csr_if.data <= '0;
      req_idle_pct = 30;
      rsp_idle_pct = 85;
      rsp_hold_cycles = 0;
      sent = 0;
      settings_used = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: wraps, limits, masking, mode decode
      load_settings(MIN_WIDTH_RST, MAX_WIDTH_RST, ALT_THRESH_RST, LOIT_THRESH_RST,
                    LAND_THRESH_RST, LOCK_THRESH_RST);
      send_event(OP_OVERFLOW, 3'd7, 1'b0, 32'hFFFF_FFFF);
      send_event(OP_OVERFLOW, 3'd0, 1'b1, 32'h0000_0000);
      send_event(OP_CAPTURE, 3'd7, 1'b1, 32'hFFFF_FFFF);
      capture(3'd0, 32'hFFFF_FFF0);
      send_event(OP_OVERFLOW, 3'd2, 1'b0, 32'h5555_AAAA);
      capture(3'd0, 32'hABCD_05D4);
      capture(3'd4, 32'h0000_0000);
      capture(3'd4, 32'd1600);
      capture(3'd6, 32'hFFFF_FF00);
      capture(3'd6, 32'h0000_0500);
      capture(3'd6, 32'd10);
      capture(3'd6, 32'd1810);
      capture(3'd5, 32'd100);
      capture(3'd5, 32'd2100);
      capture(3'd1, 32'd0);
      capture(3'd1, 32'd899);
      capture(3'd1, 32'd0);
      capture(3'd1, 32'd2101);
      capture(3'd1, 32'd5);
      capture(3'd1, 32'd905);
      capture(3'd2, 32'h0001_0000);
      capture(3'd2, 32'h0002_0834);
      wait_drained();

      load_settings(12'd0, 12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd0);
      run_random(110);
      load_random_settings();
      run_random(110);

      req_idle_pct = 85;
      rsp_idle_pct = 30;
      load_settings(12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095);
      run_random(110);
      load_random_settings();
      run_random(110);

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      load_random_settings();
      rsp_hold_cycles = 300;
      run_random(110);

      repeat (8) @(posedge clock);
      if (sb.pending.size() != 0) begin
         $error("%0d responses never arrived", sb.pending.size());
         sb.errors++;
      end
      $display("covered %0d requests and %0d responses, %0d widths stored", sent, sb.checked,
               sb.widths_stored);
      $display("across %0d register settings, input and output stalls and a long hold-off",
               settings_used);
      if (sb.errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
